// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files that carry checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define IML_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define IML_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/iml_pkg.sv -----
// Shared types and constants for the int8 MAC, requantize and table activation unit.
// No dependencies.
package iml_pkg;

    localparam int ACC_WIDTH_DEF = 32;
    localparam int BIAS_W        = 32;
    localparam int DATA_W        = 8;
    localparam int SHIFT_W       = 5;
    localparam int TABLE_DEPTH   = 256;
    localparam int TABLE_AW      = $clog2(TABLE_DEPTH);

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd8;

    localparam int SAT_MAX = 127;
    localparam int SAT_MIN = -128;
    localparam int QC_W    = 10;
    localparam int QC_MAX  = 255;
    localparam int QC_MIN  = -256;

    typedef enum logic {
        KIND_TABLE = 1'b0,
        KIND_MAC   = 1'b1
    } iml_kind_t;

    typedef struct packed {
        logic                      valid;
        iml_kind_t                 kind;
        logic [TABLE_AW-1:0]       index;
        logic signed [DATA_W-1:0]  value;
    } iml_ctl_t;

endpackage

// ----- rtl/iml_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module iml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/iml_mac.sv -----
// Input register, 8x8 multiply and wrapping accumulator stage.
// Depends on iml_pkg.
module iml_mac import iml_pkg::*; #(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic signed [DATA_W-1:0]    activation,
    input  logic signed [DATA_W-1:0]    weight,
    input  logic signed [BIAS_W-1:0]    bias,
    input  logic                        first,
    input  logic                        last,
    input  logic [TABLE_AW-1:0]         table_index,
    input  logic signed [DATA_W-1:0]    table_value,
    input  logic                        b_take,
    output iml_ctl_t                    b_ctl,
    output logic signed [ACC_WIDTH-1:0] b_sum
);

    localparam int BW = (ACC_WIDTH > BIAS_W) ? ACC_WIDTH : BIAS_W;

    logic                          a_valid_reg, a_valid_next;
    iml_kind_t                     a_kind_reg;
    logic signed [2*DATA_W-1:0]    a_prod_reg, a_prod_next;
    logic signed [BIAS_W-1:0]      a_bias_reg;
    logic                          a_first_reg;
    logic                          a_last_reg;
    logic [TABLE_AW-1:0]           a_index_reg;
    logic signed [DATA_W-1:0]      a_value_reg;

    logic signed [ACC_WIDTH-1:0]   acc_reg, acc_next;
    iml_ctl_t                      b_ctl_reg, b_ctl_next;
    logic signed [ACC_WIDTH-1:0]   b_sum_reg;

    logic                          accept;
    logic                          a_move;
    logic signed [BW-1:0]          bias_wide;
    logic signed [ACC_WIDTH-1:0]   acc_base;

    assign a_move   = a_valid_reg && (!b_ctl_reg.valid || b_take);
    assign in_stall = a_valid_reg && !a_move;
    assign accept   = in_valid && !in_stall;

    assign a_prod_next = activation * weight;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end
    end

    assign bias_wide = BW'(a_bias_reg);
    assign acc_base  = a_first_reg ? bias_wide[ACC_WIDTH-1:0] : acc_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (a_move && (a_kind_reg == KIND_MAC))
        begin
            acc_next = acc_base + ACC_WIDTH'(a_prod_reg);
        end
    end

    always_comb
    begin
        b_ctl_next = b_ctl_reg;
        if (a_move)
        begin
            // drop terms that are not the last of a dot product
            b_ctl_next.valid = (a_kind_reg == KIND_TABLE) || a_last_reg;
            b_ctl_next.kind  = a_kind_reg;
            b_ctl_next.index = a_index_reg;
            b_ctl_next.value = a_value_reg;
        end
        else if (b_take)
        begin
            b_ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            acc_reg     <= '0;
            b_ctl_reg   <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            acc_reg     <= acc_next;
            b_ctl_reg   <= b_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_kind_reg  <= iml_kind_t'(kind);
            a_prod_reg  <= a_prod_next;
            a_bias_reg  <= bias;
            a_first_reg <= first;
            a_last_reg  <= last;
            a_index_reg <= table_index;
            a_value_reg <= table_value;
        end
        if (a_move)
        begin
            b_sum_reg <= acc_next;
        end
    end

    assign b_ctl = b_ctl_reg;
    assign b_sum = b_sum_reg;

endmodule

// ----- rtl/iml_requant.sv -----
// Round-half-to-even right shift, saturation and table address stages.
// Depends on iml_pkg.
module iml_requant import iml_pkg::*; #(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  iml_ctl_t                    b_ctl,
    input  logic signed [ACC_WIDTH-1:0] b_sum,
    input  logic [SHIFT_W-1:0]          shift_amount,
    output logic                        b_take,
    input  logic                        d_take,
    output iml_ctl_t                    d_ctl,
    output logic [TABLE_AW-1:0]         d_addr
);

    localparam int W = ACC_WIDTH + BIAS_W;
    localparam logic [W-1:0]        ONE  = W'(1);
    localparam logic signed [W-1:0] Q_HI = W'(QC_MAX);
    localparam logic signed [W-1:0] Q_LO = W'(QC_MIN);
    localparam logic signed [QC_W:0] T_HI = (QC_W + 1)'(SAT_MAX);
    localparam logic signed [QC_W:0] T_LO = (QC_W + 1)'(SAT_MIN);

    iml_ctl_t                  c_ctl_reg, c_ctl_next;
    logic signed [QC_W-1:0]    c_q_reg, c_q_next;
    logic                      c_guard_reg, c_guard_next;
    logic                      c_sticky_reg, c_sticky_next;

    iml_ctl_t                  d_ctl_reg, d_ctl_next;
    logic [TABLE_AW-1:0]       d_addr_reg, d_addr_next;

    logic                      c_move;
    logic signed [W-1:0]       wide;
    logic signed [W-1:0]       q_wide;
    logic [W-1:0]              pow;
    logic [W-1:0]              half_mask;
    logic [W-1:0]              low_mask;
    logic                      round_up;
    logic signed [QC_W:0]      t_sum;
    logic signed [DATA_W-1:0]  t_sat;

    assign c_move = c_ctl_reg.valid && (!d_ctl_reg.valid || d_take);
    assign b_take = !c_ctl_reg.valid || c_move;

    assign wide      = W'(b_sum);
    assign q_wide    = wide >>> shift_amount;
    assign pow       = ONE << shift_amount;
    assign half_mask = pow >> 1;
    assign low_mask  = (pow - ONE) >> 1;

    assign c_guard_next  = |(wide & half_mask);
    assign c_sticky_next = |(wide & low_mask);

    always_comb
    begin
        if (q_wide > Q_HI)
        begin
            c_q_next = QC_W'(QC_MAX);
        end
        else if (q_wide < Q_LO)
        begin
            c_q_next = QC_W'(QC_MIN);
        end
        else
        begin
            c_q_next = q_wide[QC_W-1:0];
        end
    end

    always_comb
    begin
        c_ctl_next = c_ctl_reg;
        if (b_ctl.valid && b_take)
        begin
            c_ctl_next = b_ctl;
        end
        else if (c_move)
        begin
            c_ctl_next.valid = 1'b0;
        end
    end

    assign round_up = c_guard_reg && (c_sticky_reg || c_q_reg[0]);
    assign t_sum    = $signed({c_q_reg[QC_W-1], c_q_reg} + {{QC_W{1'b0}}, round_up});

    always_comb
    begin
        if (t_sum > T_HI)
        begin
            t_sat = DATA_W'(SAT_MAX);
        end
        else if (t_sum < T_LO)
        begin
            t_sat = DATA_W'(SAT_MIN);
        end
        else
        begin
            t_sat = t_sum[DATA_W-1:0];
        end
    end

    always_comb
    begin
        if (c_ctl_reg.kind == KIND_TABLE)
        begin
            d_addr_next = c_ctl_reg.index;
        end
        else
        begin
            // offset by 128
            d_addr_next = {~t_sat[DATA_W-1], t_sat[DATA_W-2:0]};
        end
    end

    always_comb
    begin
        d_ctl_next = d_ctl_reg;
        if (c_move)
        begin
            d_ctl_next = c_ctl_reg;
        end
        else if (d_take)
        begin
            d_ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_ctl_reg <= '0;
            d_ctl_reg <= '0;
        end
        else
        begin
            c_ctl_reg <= c_ctl_next;
            d_ctl_reg <= d_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ctl.valid && b_take)
        begin
            c_q_reg      <= c_q_next;
            c_guard_reg  <= c_guard_next;
            c_sticky_reg <= c_sticky_next;
        end
        if (c_move)
        begin
            d_addr_reg <= d_addr_next;
        end
    end

    assign d_ctl  = d_ctl_reg;
    assign d_addr = d_addr_reg;

endmodule

// ----- rtl/int8_mac_requant_lut_activation_unit.sv -----
// Top level: int8 dot product, requantize and table activation unit.
// Depends on iml_pkg, iml_ram, iml_mac, iml_requant and assert_macros.svh.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------
//   input   | in_valid / in_stall   | kind activation weight bias first last
//           |                       | table_index table_value
//   output  | out_valid / out_stall | result
//   config  | cfg_we                | cfg_data (shift_amount)
//
// One word accepted per cycle while the output does not stall; after its last term is accepted,
// a result passes the input, accumulate, shift, saturate and address, and table read registers.
// Rate is set by the single accumulator add and the one table port, both once a cycle.
// Reset clears all valid flags, the accumulator and sets the shift to 8.
// The table is not cleared; each entry is defined once written.
// A stalled output holds its word; upstream stages keep filling bubbles until full.
`include "assert_macros.svh"

module int8_mac_requant_lut_activation_unit import iml_pkg::*; #(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [SHIFT_W-1:0]         cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       kind,
    input  logic signed [DATA_W-1:0]   activation,
    input  logic signed [DATA_W-1:0]   weight,
    input  logic signed [BIAS_W-1:0]   bias,
    input  logic                       first,
    input  logic                       last,
    input  logic [TABLE_AW-1:0]        table_index,
    input  logic signed [DATA_W-1:0]   table_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [DATA_W-1:0]   result
);

    logic [SHIFT_W-1:0]          shift_reg, shift_next;
    logic                        out_valid_reg, out_valid_next;

    iml_ctl_t                    b_ctl;
    logic signed [ACC_WIDTH-1:0] b_sum;
    logic                        b_take;
    iml_ctl_t                    d_ctl;
    logic [TABLE_AW-1:0]         d_addr;
    logic                        d_take;

    logic                        ram_we;
    logic                        ram_re;
    logic [DATA_W-1:0]           ram_rdata;

    iml_mac #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .activation  (activation),
        .weight      (weight),
        .bias        (bias),
        .first       (first),
        .last        (last),
        .table_index (table_index),
        .table_value (table_value),
        .b_take      (b_take),
        .b_ctl       (b_ctl),
        .b_sum       (b_sum)
    );

    iml_requant #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_requant (
        .clk          (clk),
        .rst_n        (rst_n),
        .b_ctl        (b_ctl),
        .b_sum        (b_sum),
        .shift_amount (shift_reg),
        .b_take       (b_take),
        .d_take       (d_take),
        .d_ctl        (d_ctl),
        .d_addr       (d_addr)
    );

    // table writes never wait; a lookup waits for a free output register
    assign d_take = (d_ctl.kind == KIND_TABLE) || !out_valid_reg || !out_stall;
    assign ram_we = d_ctl.valid && (d_ctl.kind == KIND_TABLE);
    assign ram_re = d_ctl.valid && (d_ctl.kind == KIND_MAC) && d_take;

    iml_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (d_addr),
        .wdata (d_ctl.value),
        .re    (ram_re),
        .raddr (d_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        shift_next = shift_reg;
        if (cfg_we)
        begin
            shift_next = cfg_data;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ram_re)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= SHIFT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = $signed(ram_rdata);

    `IML_ASSERT(a_port_excl, clk, rst_n, !(ram_we && ram_re), "table write and read in one cycle")
    `IML_ASSERT(a_read_free, clk, rst_n, !ram_re || !out_valid_reg || !out_stall, "read over held")
    `IML_ASSERT_NEXT(a_read_out, clk, rst_n, ram_re, out_valid_reg, "lookup without output word")
    `IML_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid_reg && out_stall, out_valid_reg && $stable(result), "held word lost")

endmodule

// ----- tb/int8_mac_requant_lut_activation_unit_tb.sv -----
// Testbench for int8_mac_requant_lut_activation_unit: loads the activation table, runs dot
// products under several shift settings and checks every result word against a predictor.
// Depends on iml_pkg and the RTL of the unit.
module int8_mac_requant_lut_activation_unit_tb;
    import iml_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASE_WORDS    = 160;
    localparam int PHASE_COUNT    = 8;

    typedef struct {
        iml_kind_t                kind;
        logic signed [DATA_W-1:0] activation;
        logic signed [DATA_W-1:0] weight;
        logic signed [BIAS_W-1:0] bias;
        logic                     first;
        logic                     last;
        logic [TABLE_AW-1:0]      table_index;
        logic signed [DATA_W-1:0] table_value;
    } mac_word_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_we      = 1'b0;
    logic [SHIFT_W-1:0]       cfg_data    = SHIFT_RESET;
    logic                     in_valid    = 1'b0;
    logic                     kind        = KIND_TABLE;
    logic signed [DATA_W-1:0] activation  = '0;
    logic signed [DATA_W-1:0] weight      = '0;
    logic signed [BIAS_W-1:0] bias        = '0;
    logic                     first       = 1'b0;
    logic                     last        = 1'b0;
    logic [TABLE_AW-1:0]      table_index = '0;
    logic signed [DATA_W-1:0] table_value = '0;
    logic                     out_stall   = 1'b0;
    logic                     in_stall;
    logic                     out_valid;
    logic signed [DATA_W-1:0] result;

    mac_word_t                pending_words[$];
    logic signed [DATA_W-1:0] expected_results[$];
    int                       in_issued    = 0;
    int                       in_accepted  = 0;
    int                       error_count  = 0;
    int                       quiet_cycles = 0;
    int                       in_gap       = 0;
    int                       out_gap      = 0;
    bit                       no_idle      = 1'b0;

    logic signed [ACC_WIDTH_DEF-1:0] acc_model   = '0;
    logic [SHIFT_W-1:0]              shift_model = SHIFT_RESET;
    logic signed [DATA_W-1:0]        table_model [TABLE_DEPTH];

    int8_mac_requant_lut_activation_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .activation  (activation),
        .weight      (weight),
        .bias        (bias),
        .first       (first),
        .last        (last),
        .table_index (table_index),
        .table_value (table_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result)
    );

    always #1 clk = ~clk;

    function automatic logic signed [DATA_W-1:0] requantize(
        logic signed [ACC_WIDTH_DEF-1:0] sum, logic [SHIFT_W-1:0] sh);
        longint s;
        longint q;
        s = sum;
        if (sh == 0)
        begin
            q = s;
        end
        else
        begin
            q = (s + (longint'(1) << (sh - 1)) - 1 + longint'(s[sh])) >>> sh;
        end
        if (q > SAT_MAX)
        begin
            q = SAT_MAX;
        end
        if (q < SAT_MIN)
        begin
            q = SAT_MIN;
        end
        return table_model[TABLE_AW'(q - SAT_MIN)];
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_data();
        if ($urandom_range(0, 15) == 0)
        begin
            return '0;
        end
        return DATA_W'($urandom);
    endfunction

    function automatic logic signed [BIAS_W-1:0] pick_bias(logic [SHIFT_W-1:0] sh);
        longint span;
        case ($urandom_range(0, 9))
            0: return BIAS_W'($urandom);
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2:
            begin
                if (sh == 0)
                begin
                    return '0;
                end
                return BIAS_W'(((longint'($urandom_range(0, 400)) - 200) <<< sh)
                               + (longint'(1) << (sh - 1)));
            end
            default:
            begin
                if (sh > 22)
                begin
                    return BIAS_W'($urandom);
                end
                span = longint'(1) << (sh + 7);
                return BIAS_W'(longint'($urandom_range(0, 32'(2 * span - 1))) - span);
            end
        endcase
    endfunction

    task automatic push_mac(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] w,
                            logic signed [BIAS_W-1:0] b, logic f, logic l);
        mac_word_t x;
        x.kind        = KIND_MAC;
        x.activation  = a;
        x.weight      = w;
        x.bias        = b;
        x.first       = f;
        x.last        = l;
        x.table_index = TABLE_AW'($urandom);
        x.table_value = DATA_W'($urandom);
        pending_words.push_back(x);
    endtask

    task automatic push_table(logic [TABLE_AW-1:0] idx, logic signed [DATA_W-1:0] val);
        mac_word_t x;
        x.kind        = KIND_TABLE;
        x.activation  = DATA_W'($urandom);
        x.weight      = DATA_W'($urandom);
        x.bias        = BIAS_W'($urandom);
        x.first       = 1'($urandom);
        x.last        = 1'($urandom);
        x.table_index = idx;
        x.table_value = val;
        pending_words.push_back(x);
    endtask

    task automatic write_shift(logic [SHIFT_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || in_issued != in_accepted
               || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic gen_phase(int n, logic [SHIFT_W-1:0] sh);
        int count;
        int len;
        int r;
        count = 0;
        while (count < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 78)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 24) == 0)
                    begin
                        push_table(TABLE_AW'($urandom), DATA_W'($urandom));
                        count++;
                    end
                    push_mac(pick_data(), pick_data(),
                             (i == 0) ? pick_bias(sh) : BIAS_W'($urandom),
                             i == 0, i == len - 1);
                end
                count += len;
            end
            else if (r < 88)
            begin
                push_table(TABLE_AW'($urandom), DATA_W'($urandom));
                count++;
            end
            else
            begin
                push_mac(pick_data(), pick_data(), pick_bias(sh), 1'($urandom), 1'($urandom));
                count++;
            end
        end
    endtask

    // Driver: hold the word until accepted, then idle or advance.
    always @(negedge clk)
    begin
        mac_word_t w;
        if (rst_n && !(in_valid && in_accepted != in_issued))
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap--;
            end
            else if (!no_idle && $urandom_range(0, 19) == 0)
            begin
                in_valid <= 1'b0;
                in_gap = $urandom_range(0, 16);
            end
            else if (pending_words.size() != 0)
            begin
                w = pending_words.pop_front();
                kind        <= w.kind;
                activation  <= w.activation;
                weight      <= w.weight;
                bias        <= w.bias;
                first       <= w.first;
                last        <= w.last;
                table_index <= w.table_index;
                table_value <= w.table_value;
                in_valid    <= 1'b1;
                in_issued++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_stall <= 1'b1;
            out_gap--;
        end
        else if (!no_idle && $urandom_range(0, 19) == 0)
        begin
            out_stall <= 1'b1;
            out_gap = $urandom_range(0, 16);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: check result words, predict from accepted input words.
    always @(posedge clk)
    begin
        logic signed [DATA_W-1:0] want;
        int                       prod;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                shift_model = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result: expected none, actual %0d", result);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result !== want)
                    begin
                        $error("result: expected %0d, actual %0d", want, result);
                        error_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                in_accepted++;
                if (kind == KIND_TABLE)
                begin
                    table_model[table_index] = table_value;
                end
                else
                begin
                    prod = int'(activation) * int'(weight);
                    if (first)
                    begin
                        acc_model = bias;
                    end
                    acc_model = acc_model + prod;
                    if (last)
                    begin
                        expected_results.push_back(requantize(acc_model, shift_model));
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        logic [SHIFT_W-1:0] shift_plan [PHASE_COUNT];
        shift_plan = '{5'd1, 5'd31, 5'd0, 5'd4, 5'd12, 5'd7, 5'd16, 5'd8};
        shift_plan[5] = SHIFT_W'($urandom_range(1, 30));
        foreach (table_model[i])
        begin
            table_model[i] = '0;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_shift(SHIFT_RESET);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            push_table(TABLE_AW'(i), DATA_W'($urandom));
        end
        drain();

        push_mac(0, 0, 0, 1'b1, 1'b1);
        push_mac(-128, -128, 0, 1'b1, 1'b1);
        push_mac(127, 127, 0, 1'b1, 1'b1);
        push_mac(-128, 127, 0, 1'b1, 1'b1);
        push_mac(0, 0, 384, 1'b1, 1'b1);
        push_mac(0, 0, 640, 1'b1, 1'b1);
        push_mac(0, 0, -384, 1'b1, 1'b1);
        push_mac(0, 0, -640, 1'b1, 1'b1);
        push_mac(0, 0, 32'h7fffffff, 1'b1, 1'b1);
        push_mac(0, 0, 32'h80000000, 1'b1, 1'b1);
        push_mac(0, 0, 32'h7fffffff, 1'b1, 1'b0);
        push_mac(127, 127, 0, 1'b0, 1'b1);
        push_mac(-128, -128, 1000, 1'b1, 1'b0);
        push_mac(-128, -128, 0, 1'b0, 1'b0);
        push_mac(127, -128, 0, 1'b0, 1'b0);
        push_mac(-1, 1, 0, 1'b0, 1'b1);
        push_mac(64, 64, 0, 1'b0, 1'b1);
        push_table(8'd128, 127);
        push_mac(0, 0, 0, 1'b1, 1'b1);
        push_table(8'd128, -128);
        push_mac(0, 0, 0, 1'b1, 1'b1);
        push_table(8'd0, 8'sh55);
        push_table(8'd255, 8'shaa);
        push_mac(0, 0, 32'h80000000, 1'b1, 1'b1);
        push_mac(0, 0, 32'h7fffffff, 1'b1, 1'b1);
        drain();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == PHASE_COUNT - 1)
            begin
                no_idle = 1'b1;
            end
            write_shift(shift_plan[p]);
            gen_phase(PHASE_WORDS, shift_plan[p]);
            drain();
        end

        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/iml_pkg.sv
rtl/iml_ram.sv
rtl/iml_mac.sv
rtl/iml_requant.sv
rtl/int8_mac_requant_lut_activation_unit.sv
tb/int8_mac_requant_lut_activation_unit_tb.sv
